/* rtl/tps_pkg.sv */
// Shared constants, metric codes and handshake types for the trade PnL statistics block.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package tps_pkg;

	// Store depth and derived widths
	localparam int MAX_TRADES = 1024;
	localparam int ADDR_W     = (MAX_TRADES > 1) ? $clog2(MAX_TRADES) : 1;
	localparam int CNT_W      = $clog2(MAX_TRADES + 1);
	localparam int PNL_W      = 24;
	localparam int RUN_W      = 40;
	localparam int VAL_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int MEAN_W     = 32;
	localparam int ACC_W      = 2 * ROOT_W + CNT_W;
	localparam int NUM_W      = ACC_W;
	localparam int DEN_W      = RUN_W;
	localparam int ITER_W     = $clog2(NUM_W + 1);

	// Metric codes on the result channel
	localparam logic [3:0] M_DRAWDOWN     = 4'd0;
	localparam logic [3:0] M_TOTAL        = 4'd1;
	localparam logic [3:0] M_COUNT        = 4'd2;
	localparam logic [3:0] M_WIN_RATE     = 4'd3;
	localparam logic [3:0] M_PROFIT_FACT  = 4'd4;
	localparam logic [3:0] M_SHARPE       = 4'd5;
	localparam logic [3:0] M_SORTINO      = 4'd6;
	localparam logic [3:0] M_CALMAR       = 4'd7;
	localparam logic [3:0] M_MAX_DD       = 4'd8;
	localparam logic [3:0] M_WINS         = 4'd9;
	localparam logic [3:0] M_LOSSES       = 4'd10;
	localparam logic [3:0] M_AVG_WIN      = 4'd11;
	localparam logic [3:0] M_AVG_LOSS     = 4'd12;
	localparam logic [3:0] M_LARGEST_WIN  = 4'd13;
	localparam logic [3:0] M_LARGEST_LOSS = 4'd14;
	localparam logic [3:0] M_VOLATILITY   = 4'd15;

	// Input command codes
	localparam logic CMD_TRADE  = 1'b0;
	localparam logic CMD_REPORT = 1'b1;

	// Shared arithmetic unit operations
	typedef enum logic {
		OP_DIV,
		OP_SQRT
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} arith_req_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] result;
	} arith_rsp_t;

endpackage
`default_nettype wire

/* rtl/tps_arith.sv */
// Shared bit-serial arithmetic unit: unsigned restoring divide and floor square root.
// Depends on tps_pkg for widths and the request/response types.
`timescale 1ns / 1ps
`default_nettype none
module tps_arith (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire tps_pkg::arith_req_t     req,
	input  wire logic [tps_pkg::NUM_W-1:0] num,
	input  wire logic [tps_pkg::DEN_W-1:0] den,
	output tps_pkg::arith_rsp_t          rsp
);
	import tps_pkg::*;

	localparam int TRY_W = DEN_W + 2;

	logic              busy_q;
	logic              done_q;
	op_t               op_q;
	logic [ITER_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  sh_q;
	logic [ROOT_W-1:0] root_q;

	logic [TRY_W-1:0]  try_a;
	logic [TRY_W-1:0]  try_b;
	logic [TRY_W-1:0]  diff;
	logic              ge;

	// Trial subtract: one quotient bit or one root bit per cycle
	always_comb begin
		if (op_q == OP_DIV) begin
			try_a = {1'b0, rem_q, sh_q[NUM_W-1]};
			try_b = TRY_W'(den_q);
		end else begin
			try_a = {rem_q, sh_q[NUM_W-1 -: 2]};
			try_b = TRY_W'({root_q, 2'b01});
		end
		diff = try_a - try_b;
		ge   = (try_a >= try_b);
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_DIV;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == OP_DIV) ? ITER_W'(NUM_W - 1) : ITER_W'(ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then shift one step per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			den_q  <= den;
			root_q <= '0;
			if (req.op == OP_DIV) begin
				sh_q <= num;
			end else begin
				sh_q <= {num[VAL_W-1:0], {(NUM_W - VAL_W){1'b0}}};
			end
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DEN_W-1:0] : try_a[DEN_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
			if (op_q == OP_DIV) begin
				sh_q <= {sh_q[NUM_W-2:0], ge};
			end else begin
				sh_q <= {sh_q[NUM_W-3:0], 2'b00};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = (op_q == OP_DIV) ? sh_q[VAL_W-1:0] : VAL_W'(root_q);

endmodule
`default_nettype wire

/* rtl/trade_pnl_statistics_unit.sv */
// Top level of the trade PnL statistics block: trade store, running registers, report sequencer.
// Depends on tps_pkg and instantiates tps_arith (shared divide / square root unit).
//
// Usage:
//   Input stream s_axis: tuser[0] = cmd (0 add trade, 1 report and clear),
//   tdata[23:0] = pnl (signed, 8 fraction bits). One transaction per item.
//   Output stream m_axis: tdata = value (signed Q.16 or plain count),
//   tuser[3:0] = metric, tuser[4] = overflowed, tlast on the final result.
//   A trade returns one drawdown result; a report returns fifteen metrics
//   (codes 1..15) and then clears all running state and the overflow flag.
// Timing:
//   s_axis_tready is high only while the block is idle; one item is in work
//   at a time. A trade passes the peak and drawdown states before its result is valid.
//   A report runs a restoring divider that yields one quotient bit a cycle
//   (NUM_W = 75 quotient bits per division) and a 32-bit square root:
//   mean divide, a store walk, two variance divides, two roots, then up to
//   seven metric divides.
// Reset: arst_n clears all counters, sums and the overflow flag; the store
//   contents are not cleared, only entries below the trade count are read.
// Stall: a result is held on m_axis until taken; no new item is accepted
//   until the last result of the current item has been transferred.
`timescale 1ns / 1ps
`default_nettype none
module trade_pnl_statistics_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // [23:0] pnl
	input  wire logic [0:0]  s_axis_tuser,   // [0] cmd
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,   // [63:0] value
	output logic [4:0]       m_axis_tuser,   // [3:0] metric, [4] overflowed
	output logic             m_axis_tlast
);
	import tps_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE      = 9'b000000001,
		S_TPEAK     = 9'b000000010,
		S_TDD       = 9'b000000100,
		S_PRE_START = 9'b000001000,
		S_PRE_WAIT  = 9'b000010000,
		S_WALK      = 9'b000100000,
		S_MET_START = 9'b001000000,
		S_MET_WAIT  = 9'b010000000,
		S_EMIT      = 9'b100000000
	} state_t;

	// Precompute step codes
	localparam logic [2:0] PRE_MEAN      = 3'd0;
	localparam logic [2:0] PRE_VAR       = 3'd1;
	localparam logic [2:0] PRE_DVAR      = 3'd2;
	localparam logic [2:0] PRE_VOL       = 3'd3;
	localparam logic [2:0] PRE_DOWN      = 3'd4;

	state_t                   state_q;
	logic [CNT_W-1:0]         trade_count_q;
	logic [CNT_W-1:0]         win_count_q;
	logic signed [RUN_W-1:0]  running_total_q;
	logic signed [RUN_W-1:0]  running_peak_q;
	logic signed [RUN_W-1:0]  worst_drawdown_q;
	logic signed [RUN_W-1:0]  gross_profit_q;
	logic signed [RUN_W-1:0]  gross_loss_q;
	logic signed [PNL_W-1:0]  largest_gain_q;
	logic signed [PNL_W-1:0]  largest_drop_q;
	logic                     dropped_q;

	logic [PNL_W-1:0]         trade_store [MAX_TRADES];

	logic [2:0]               pre_q;
	logic [3:0]               met_q;
	logic [VAL_W-1:0]         out_val_q;
	logic                     op_neg_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic [VAL_W-1:0]         var_q;
	logic [VAL_W-1:0]         dvar_q;
	logic [ROOT_W-1:0]        vol_q;
	logic [ROOT_W-1:0]        down_q;

	// Store walk pipeline
	logic [CNT_W-1:0]         issue_q;
	logic                     v_s1, v_s2, v_s3;
	logic [PNL_W-1:0]         rd_s1;
	logic [ROOT_W-1:0]        mag_s2;
	logic                     neg_s2, neg_s3;
	logic [2*ROOT_W-1:0]      sq_s3;
	logic [ACC_W-1:0]         vacc_q;
	logic [ACC_W-1:0]         dacc_q;

	logic                     in_fire;
	logic                     out_fire;
	logic                     trade_wr;
	logic                     store_full;
	logic signed [PNL_W-1:0]  pnl;
	logic signed [RUN_W-1:0]  pnl_ext;
	logic signed [RUN_W-1:0]  dd;
	logic [CNT_W-1:0]         losses;
	logic [RUN_W-1:0]         tot_mag;
	logic [MEAN_W-1:0]        mean_mag;
	logic signed [MEAN_W:0]   dev;
	logic                     walk_done;

	logic [NUM_W-1:0]         op_num;
	logic [DEN_W-1:0]         op_den;
	logic                     op_neg;
	op_t                      op_kind;
	logic                     op_use;
	logic                     op_skip;
	logic [VAL_W-1:0]         direct_val;
	logic [VAL_W-1:0]         quo_signed;

	arith_req_t               arith_req;
	arith_rsp_t               arith_rsp;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == S_EMIT);
	assign out_fire      = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = out_val_q;
	assign m_axis_tuser  = {dropped_q, met_q};
	assign m_axis_tlast  = (met_q == M_DRAWDOWN) || (met_q == M_VOLATILITY);

	assign pnl        = $signed(s_axis_tdata[PNL_W-1:0]);
	assign pnl_ext    = RUN_W'(pnl);
	assign store_full = (trade_count_q == CNT_W'(MAX_TRADES));
	assign trade_wr   = in_fire && (s_axis_tuser[0] == CMD_TRADE) && !store_full;
	assign dd         = running_peak_q - running_total_q;
	assign losses     = trade_count_q - win_count_q;
	assign tot_mag    = running_total_q[RUN_W-1] ? RUN_W'(-running_total_q) : running_total_q;
	assign mean_mag   = mean_q[MEAN_W-1] ? MEAN_W'(-mean_q) : mean_q;
	assign walk_done  = (issue_q == trade_count_q) && !v_s1 && !v_s2 && !v_s3;
	assign dev        = $signed({rd_s1[PNL_W-1], rd_s1, 8'b0}) - $signed({mean_q[MEAN_W-1], mean_q});

	// Operands of the shared unit for the current precompute step or metric
	always_comb begin
		op_num     = '0;
		op_den     = DEN_W'(trade_count_q);
		op_neg     = 1'b0;
		op_kind    = OP_DIV;
		op_use     = 1'b0;
		direct_val = '0;
		if (state_q == S_PRE_START) begin
			op_use = 1'b1;
			case (pre_q)
				PRE_MEAN: begin
					op_num = NUM_W'({tot_mag, 8'b0});
					op_neg = running_total_q[RUN_W-1];
				end
				PRE_VAR:  op_num = NUM_W'(vacc_q);
				PRE_DVAR: op_num = NUM_W'(dacc_q);
				PRE_VOL: begin
					op_kind = OP_SQRT;
					op_num  = NUM_W'(var_q);
				end
				PRE_DOWN: begin
					op_kind = OP_SQRT;
					op_num  = NUM_W'(dvar_q);
				end
				default: op_use = 1'b0;
			endcase
		end else begin
			case (met_q)
				M_TOTAL: direct_val = {{(VAL_W-RUN_W-8){running_total_q[RUN_W-1]}},
					running_total_q, 8'b0};
				M_COUNT: direct_val = VAL_W'(trade_count_q);
				M_WIN_RATE: begin
					op_use = 1'b1;
					op_num = NUM_W'({win_count_q, 16'b0});
				end
				M_PROFIT_FACT: begin
					op_use = 1'b1;
					op_num = NUM_W'({gross_profit_q, 16'b0});
					op_den = gross_loss_q;
				end
				M_SHARPE: begin
					op_use = 1'b1;
					op_num = NUM_W'({mean_mag, 16'b0});
					op_den = DEN_W'(vol_q);
					op_neg = mean_q[MEAN_W-1];
				end
				M_SORTINO: begin
					op_use = 1'b1;
					op_num = NUM_W'({mean_mag, 16'b0});
					op_den = DEN_W'(down_q);
					op_neg = mean_q[MEAN_W-1];
				end
				M_CALMAR: begin
					op_use = 1'b1;
					op_num = NUM_W'({tot_mag, 16'b0});
					op_den = worst_drawdown_q;
					op_neg = running_total_q[RUN_W-1];
				end
				M_MAX_DD: direct_val = {{(VAL_W-RUN_W-8){worst_drawdown_q[RUN_W-1]}},
					worst_drawdown_q, 8'b0};
				M_WINS:   direct_val = VAL_W'(win_count_q);
				M_LOSSES: direct_val = VAL_W'(losses);
				M_AVG_WIN: begin
					op_use = 1'b1;
					op_num = NUM_W'({gross_profit_q, 8'b0});
					op_den = DEN_W'(win_count_q);
				end
				M_AVG_LOSS: begin
					op_use = 1'b1;
					op_num = NUM_W'({gross_loss_q, 8'b0});
					op_den = DEN_W'(losses);
				end
				M_LARGEST_WIN: direct_val = {{(VAL_W-PNL_W-8){largest_gain_q[PNL_W-1]}},
					largest_gain_q, 8'b0};
				M_LARGEST_LOSS: direct_val = {{(VAL_W-PNL_W-8){largest_drop_q[PNL_W-1]}},
					largest_drop_q, 8'b0};
				M_VOLATILITY: direct_val = VAL_W'(vol_q);
				default: direct_val = '0;
			endcase
		end
		op_skip = (op_kind == OP_DIV) && (op_den == '0);
	end

	assign arith_req.start = ((state_q == S_PRE_START) || (state_q == S_MET_START))
		&& op_use && !op_skip;
	assign arith_req.op    = op_kind;
	assign quo_signed      = op_neg_q ? VAL_W'(-arith_rsp.result) : arith_rsp.result;

	tps_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (arith_req),
		.num    (op_num),
		.den    (op_den),
		.rsp    (arith_rsp)
	);

	// Trade store: write on an accepted trade while not full, registered read for the walk
	always_ff @(posedge clk) begin
		if (trade_wr) begin
			trade_store[trade_count_q[ADDR_W-1:0]] <= s_axis_tdata[PNL_W-1:0];
		end
		rd_s1 <= trade_store[issue_q[ADDR_W-1:0]];
	end

	// Walk datapath: deviation magnitude, square, then accumulate
	always_ff @(posedge clk) begin
		neg_s2 <= dev[MEAN_W];
		mag_s2 <= dev[MEAN_W] ? MEAN_W'(-dev) : dev[MEAN_W-1:0];
		neg_s3 <= neg_s2;
		sq_s3  <= mag_s2 * mag_s2;
	end

	// Sequencer and running registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			trade_count_q    <= '0;
			win_count_q      <= '0;
			running_total_q  <= '0;
			running_peak_q   <= '0;
			worst_drawdown_q <= '0;
			gross_profit_q   <= '0;
			gross_loss_q     <= '0;
			largest_gain_q   <= '0;
			largest_drop_q   <= '0;
			dropped_q        <= 1'b0;
			pre_q            <= PRE_MEAN;
			met_q            <= M_DRAWDOWN;
			out_val_q        <= '0;
			op_neg_q         <= 1'b0;
			mean_q           <= '0;
			var_q            <= '0;
			dvar_q           <= '0;
			vol_q            <= '0;
			down_q           <= '0;
			issue_q          <= '0;
			v_s1             <= 1'b0;
			v_s2             <= 1'b0;
			v_s3             <= 1'b0;
			vacc_q           <= '0;
			dacc_q           <= '0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				vacc_q <= vacc_q + ACC_W'(sq_s3);
				if (neg_s3) begin
					dacc_q <= dacc_q + ACC_W'(sq_s3);
				end
			end
			if (arith_req.start) begin
				op_neg_q <= op_neg;
			end

			case (state_q)
				// Accept a trade or start a report
				S_IDLE: begin
					if (in_fire) begin
						if (s_axis_tuser[0] == CMD_REPORT) begin
							issue_q <= '0;
							vacc_q  <= '0;
							dacc_q  <= '0;
							if (trade_count_q == '0) begin
								mean_q  <= '0;
								vol_q   <= '0;
								down_q  <= '0;
								met_q   <= M_TOTAL;
								state_q <= S_MET_START;
							end else begin
								pre_q   <= PRE_MEAN;
								state_q <= S_PRE_START;
							end
						end else begin
							if (store_full) begin
								dropped_q <= 1'b1;
							end else begin
								trade_count_q   <= trade_count_q + 1'b1;
								running_total_q <= running_total_q + pnl_ext;
								if (trade_count_q == '0) begin
									largest_gain_q <= pnl;
									largest_drop_q <= pnl;
								end else begin
									if (pnl > largest_gain_q) largest_gain_q <= pnl;
									if (pnl < largest_drop_q) largest_drop_q <= pnl;
								end
								if (pnl > 0) begin
									win_count_q    <= win_count_q + 1'b1;
									gross_profit_q <= gross_profit_q + pnl_ext;
								end else begin
									gross_loss_q <= gross_loss_q - pnl_ext;
								end
							end
							state_q <= S_TPEAK;
						end
					end
				end
				// Advance the peak
				S_TPEAK: begin
					if (running_total_q > running_peak_q) begin
						running_peak_q <= running_total_q;
					end
					state_q <= S_TDD;
				end
				// Update worst drawdown and load the trade result
				S_TDD: begin
					if (dd > worst_drawdown_q) begin
						worst_drawdown_q <= dd;
					end
					out_val_q <= {{(VAL_W-RUN_W-8){dd[RUN_W-1]}}, dd, 8'b0};
					met_q     <= M_DRAWDOWN;
					state_q   <= S_EMIT;
				end
				S_PRE_START: begin
					state_q <= S_PRE_WAIT;
				end
				// Collect a precompute result
				S_PRE_WAIT: begin
					if (arith_rsp.done) begin
						case (pre_q)
							PRE_MEAN: mean_q <= quo_signed[MEAN_W-1:0];
							PRE_VAR:  var_q  <= arith_rsp.result;
							PRE_DVAR: dvar_q <= arith_rsp.result;
							PRE_VOL:  vol_q  <= arith_rsp.result[ROOT_W-1:0];
							PRE_DOWN: down_q <= arith_rsp.result[ROOT_W-1:0];
							default:  mean_q <= mean_q;
						endcase
						if (pre_q == PRE_MEAN) begin
							state_q <= S_WALK;
						end else if (pre_q == PRE_DOWN) begin
							met_q   <= M_TOTAL;
							state_q <= S_MET_START;
						end else begin
							pre_q   <= pre_q + 1'b1;
							state_q <= S_PRE_START;
						end
					end
				end
				// Issue one store read a cycle until the pipeline drains
				S_WALK: begin
					if (issue_q != trade_count_q) begin
						v_s1    <= 1'b1;
						issue_q <= issue_q + 1'b1;
					end else begin
						v_s1 <= 1'b0;
					end
					if (walk_done) begin
						pre_q   <= PRE_VAR;
						state_q <= S_PRE_START;
					end
				end
				// Launch a metric division, or take a direct value (zero for a division by zero)
				S_MET_START: begin
					if (op_use && !op_skip) begin
						state_q <= S_MET_WAIT;
					end else begin
						out_val_q <= op_use ? '0 : direct_val;
						state_q   <= S_EMIT;
					end
				end
				S_MET_WAIT: begin
					if (arith_rsp.done) begin
						out_val_q <= quo_signed;
						state_q   <= S_EMIT;
					end
				end
				// Hold the result until taken
				S_EMIT: begin
					if (out_fire) begin
						if (met_q == M_DRAWDOWN) begin
							state_q <= S_IDLE;
						end else if (met_q == M_VOLATILITY) begin
							trade_count_q    <= '0;
							win_count_q      <= '0;
							running_total_q  <= '0;
							running_peak_q   <= '0;
							worst_drawdown_q <= '0;
							gross_profit_q   <= '0;
							gross_loss_q     <= '0;
							largest_gain_q   <= '0;
							largest_drop_q   <= '0;
							dropped_q        <= 1'b0;
							state_q          <= S_IDLE;
						end else begin
							met_q   <= met_q + 1'b1;
							state_q <= S_MET_START;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Input and output never both active
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input accepted while a result is pending");

	// Trade count stays within the store
	assert property (@(posedge clk) disable iff (!arst_n)
		trade_count_q <= CNT_W'(MAX_TRADES))
		else $error("trade count beyond store depth");

	// Wins never exceed trades
	assert property (@(posedge clk) disable iff (!arst_n)
		win_count_q <= trade_count_q)
		else $error("win count exceeds trade count");

	// Peak never below the running total when idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (running_peak_q >= running_total_q))
		else $error("peak below running total");

	// Report end clears the state
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && (met_q == M_VOLATILITY)) |=> (trade_count_q == '0) && !dropped_q)
		else $error("state not cleared after report");

endmodule
`default_nettype wire
